// ----- hw/rtl/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
// No dependencies; imported by ffha_alu and first_fit_heap_allocator.
package ffha_pkg;

	// Field widths of the request and response beats.
	localparam int unsigned REQ_W      = 16;
	localparam int unsigned ADDR_W     = 13;
	localparam int unsigned SUM_W      = 14;
	localparam int unsigned STATUS_W   = 2;

	// Rounded size is at most 65536, so it needs 17 bits.
	localparam int unsigned SIZE_W     = 17;

	// Reciprocal multiply used to round a request up to whole words.
	localparam int unsigned RND_SHIFT  = 21;
	localparam int unsigned RND_MULT_W = 22;
	localparam int unsigned PROD_W     = SIZE_W + RND_MULT_W;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_NOADDR = 2'd2,
		ST_FULL   = 2'd3
	} ffha_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROUND,
		S_SIZE,
		S_SCAN,
		S_PATCH,
		S_REM0,
		S_REM,
		S_INS0,
		S_INS,
		S_DONE
	} ffha_state_t;

	typedef struct packed {
		logic borrow;
		logic zero;
	} ffha_flags_t;

endpackage

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator: sequencer, region tables and response register.
// Depends on ffha_pkg, ffha_ram and ffha_alu.
//
// One request is handled at a time; req_ready is high only while the sequencer is idle,
// and a finished response waits in its own register so the next request can be taken.
// Both region tables sit in RAMs with one read and one write port, and one shared
// subtract/compare unit makes the scan and insert comparisons, so the time per request is
// set by those ports: a table scan reads one entry at a time, a sorted insert or a removal
// moves one entry at a time, and rounding the size adds the ROUND and SIZE states.
// An allocate scans the free table up to the first fitting region, moves free entries up
// on an exact fit and moves allocated entries on insert; a free does about the same with
// the roles of the tables swapped. No clearing pass is needed after reset.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int unsigned HEAP_WORDS    = 1024,
	parameter int unsigned WORD_BYTES    = 8,
	parameter int unsigned LIST_CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                mode,
	input  logic [REQ_W-1:0]    request_bytes,
	input  logic [ADDR_W-1:0]   region_address,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [ADDR_W-1:0]   granted_address,
	output logic [STATUS_W-1:0] status,
	output logic [SUM_W-1:0]    free_bytes,
	output logic [SUM_W-1:0]    allocated_bytes
);

	localparam int unsigned HEAP_BYTES = HEAP_WORDS * WORD_BYTES;
	localparam int unsigned LW = $clog2(HEAP_BYTES + 1);
	localparam int unsigned DW = (LW > SIZE_W) ? LW : SIZE_W;
	localparam int unsigned CW = $clog2(LIST_CAPACITY + 1);
	localparam int unsigned AW = $clog2(LIST_CAPACITY);
	localparam int unsigned EW = 2 * LW;
	localparam int unsigned QW = PROD_W - RND_SHIFT;
	localparam logic [LW-1:0] HEAP_LEN = LW'(HEAP_BYTES);
	localparam logic [CW-1:0] CAP_C = CW'(LIST_CAPACITY);
	localparam logic [RND_MULT_W-1:0] RND_M =
		RND_MULT_W'(((1 << RND_SHIFT) + WORD_BYTES - 1) / WORD_BYTES);

	ffha_state_t  state_q, state_d;
	ffha_status_t status_q;

	logic              mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [REQ_W-1:0]  reqb_q;
	logic [PROD_W-1:0] prod_q;
	logic [DW-1:0]     len_q;
	logic [LW-1:0]     s_q;
	logic [LW-1:0]     rem_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     free_cnt_q, used_cnt_q;
	logic [LW-1:0]     free_sum_q, used_sum_q;
	logic              boot_q;
	logic              rd_vld_s1;
	logic              ovr_s1;

	logic                rsp_valid_q;
	logic [ADDR_W-1:0]   rsp_granted_q;
	ffha_status_t        rsp_status_q;
	logic [SUM_W-1:0]    rsp_free_q, rsp_alloc_q;

	// Rounding datapath.
	logic [SIZE_W-1:0] rnd_x;
	logic [PROD_W-1:0] prod_d;
	logic [QW-1:0]     quot;
	logic [QW-1:0]     size_full;

	// Table access.
	logic          tbl_used;
	logic [CW-1:0] tbl_cnt;
	logic          tbl_full;
	logic          tbl_we;
	logic          f_we, u_we;
	logic [AW-1:0] wr_idx, rd_idx;
	logic [EW-1:0] wr_ent;
	logic [EW-1:0] f_rdata, u_rdata, ent;
	logic [LW-1:0] ent_start, ent_len;
	logic [EW-1:0] ins_ent;

	logic [CW-1:0] ptr_m1, ptr_m2, ptr_p2, cnt_m1, idx_ext_p1;

	logic [DW-1:0] alu_a, alu_b, alu_diff;
	ffha_flags_t   alu_flags;

	logic in_acc, rsp_load;
	logic scan_hit, scan_miss, scan_issue, scan_go;
	logic ins_shift, ins_done, rem_prime, rem_done;
	ffha_state_t after_ins, after_rem;

	logic [DW-1:0] s_ext, free_ext, used_ext;

	assign req_ready = (state_q == S_IDLE);
	assign in_acc    = req_valid && req_ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// Round up to whole words: floor((req + WB - 1) / WB) by reciprocal multiply.
	assign rnd_x     = SIZE_W'(reqb_q) + SIZE_W'(WORD_BYTES - 1);
	assign prod_d    = PROD_W'(rnd_x) * PROD_W'(RND_M);
	assign quot      = prod_q[PROD_W-1:RND_SHIFT];
	assign size_full = quot * QW'(WORD_BYTES);

	always_comb begin
		tbl_used = 1'b0;
		case (state_q) inside
			S_SCAN, S_REM0, S_REM: tbl_used = (mode_q == MODE_FREE);
			S_INS0, S_INS:         tbl_used = (mode_q == MODE_ALLOC);
			default:               tbl_used = 1'b0;
		endcase
	end

	assign tbl_cnt  = tbl_used ? used_cnt_q : free_cnt_q;
	assign tbl_full = (mode_q == MODE_FREE) ? (free_cnt_q >= CAP_C) : (used_cnt_q >= CAP_C);

	// Entry 0 of the free table reads as the whole heap until it is first written.
	assign ent       = tbl_used ? u_rdata : (ovr_s1 ? {{LW{1'b0}}, HEAP_LEN} : f_rdata);
	assign ent_start = ent[EW-1:LW];
	assign ent_len   = ent[LW-1:0];
	assign ins_ent   = {s_q, len_q[LW-1:0]};

	assign ptr_m1     = ptr_q - CW'(1);
	assign ptr_m2     = ptr_q - CW'(2);
	assign ptr_p2     = ptr_q + CW'(2);
	assign cnt_m1     = tbl_cnt - CW'(1);
	assign idx_ext_p1 = CW'(idx_q) + CW'(1);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_SCAN: begin
				if (mode_q == MODE_FREE) begin
					alu_a = DW'(addr_q);
					alu_b = DW'(ent_start);
				end else begin
					alu_a = DW'(ent_len);
					alu_b = len_q;
				end
			end
			S_INS: begin
				alu_a = DW'(s_q);
				alu_b = DW'(ent_start);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	ffha_alu #(
		.W(DW)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.flags(alu_flags)
	);

	// The scan reads one entry per cycle; the compare works on the registered read data, in the cycle after the read.
	assign scan_hit   = (state_q == S_SCAN) && rd_vld_s1 &&
		((mode_q == MODE_FREE) ? alu_flags.zero : !alu_flags.borrow);
	assign scan_miss  = (state_q == S_SCAN) && !rd_vld_s1 && (ptr_q >= tbl_cnt);
	assign scan_issue = (state_q == S_SCAN) && !scan_hit && (ptr_q < tbl_cnt);
	assign scan_go    = scan_hit && !tbl_full;

	// Insert walks down from the top, moving entries whose start lies above the new one.
	assign ins_shift  = (state_q == S_INS) && rd_vld_s1 && alu_flags.borrow;
	assign ins_done   = ((state_q == S_INS0) && (tbl_cnt == '0)) ||
		((state_q == S_INS) && !ins_shift);
	assign rem_prime  = (state_q == S_REM0) && (idx_ext_p1 < tbl_cnt);
	assign rem_done   = ((state_q == S_REM0) && !rem_prime) ||
		((state_q == S_REM) && !rd_vld_s1);

	assign after_ins = (mode_q == MODE_FREE) ? S_REM0 : S_DONE;
	assign after_rem = (mode_q == MODE_FREE) ? S_DONE : S_INS0;

	always_comb begin
		state_d = state_q;
		tbl_we  = 1'b0;
		wr_idx  = '0;
		wr_ent  = '0;
		rd_idx  = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (mode == MODE_FREE) begin
						state_d = S_SCAN;
					end else if (request_bytes == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_ROUND;
					end
				end
			end
			S_ROUND: state_d = S_SIZE;
			S_SIZE:  state_d = S_SCAN;
			S_SCAN: begin
				if (scan_hit) begin
					if (tbl_full) begin
						state_d = S_DONE;
					end else if (mode_q == MODE_FREE) begin
						state_d = S_INS0;
					end else if (alu_flags.zero) begin
						state_d = S_REM0;
					end else begin
						state_d = S_PATCH;
					end
				end else if (scan_miss) begin
					state_d = S_DONE;
				end
			end
			S_PATCH: begin
				// The remainder stays in the slot of the region it came from.
				tbl_we  = 1'b1;
				wr_idx  = idx_q;
				wr_ent  = {s_q + len_q[LW-1:0], rem_q};
				state_d = S_INS0;
			end
			S_INS0: begin
				rd_idx = cnt_m1[AW-1:0];
				if (tbl_cnt == '0) begin
					tbl_we  = 1'b1;
					wr_idx  = '0;
					wr_ent  = ins_ent;
					state_d = after_ins;
				end else begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				rd_idx = ptr_m2[AW-1:0];
				tbl_we = 1'b1;
				wr_idx = ptr_q[AW-1:0];
				if (ins_shift) begin
					wr_ent = ent;
				end else begin
					wr_ent  = ins_ent;
					state_d = after_ins;
				end
			end
			S_REM0: begin
				rd_idx = idx_ext_p1[AW-1:0];
				if (!rem_prime) begin
					state_d = after_rem;
				end else begin
					state_d = S_REM;
				end
			end
			S_REM: begin
				rd_idx = ptr_p2[AW-1:0];
				if (rd_vld_s1) begin
					tbl_we = 1'b1;
					wr_idx = ptr_q[AW-1:0];
					wr_ent = ent;
				end else begin
					state_d = after_rem;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign f_we = tbl_we && !tbl_used;
	assign u_we = tbl_we && tbl_used;

	ffha_ram #(
		.WIDTH(EW),
		.DEPTH(LIST_CAPACITY)
	) u_free_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(wr_idx),
		.wdata(wr_ent),
		.raddr(rd_idx),
		.rdata(f_rdata)
	);

	ffha_ram #(
		.WIDTH(EW),
		.DEPTH(LIST_CAPACITY)
	) u_used_ram (
		.clk  (clk),
		.we   (u_we),
		.waddr(wr_idx),
		.wdata(wr_ent),
		.raddr(rd_idx),
		.rdata(u_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_cnt_q  <= CW'(1);
			used_cnt_q  <= '0;
			free_sum_q  <= HEAP_LEN;
			used_sum_q  <= '0;
			boot_q      <= 1'b1;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			case (state_q)
				S_SCAN:  rd_vld_s1 <= scan_issue;
				S_INS0:  rd_vld_s1 <= (tbl_cnt != '0);
				S_INS:   rd_vld_s1 <= ins_shift && (ptr_q > CW'(1));
				S_REM0:  rd_vld_s1 <= rem_prime;
				S_REM:   rd_vld_s1 <= rd_vld_s1 && (ptr_p2 < tbl_cnt);
				default: rd_vld_s1 <= 1'b0;
			endcase

			if (scan_go) begin
				if (mode_q == MODE_FREE) begin
					free_sum_q <= free_sum_q + ent_len;
					used_sum_q <= used_sum_q - ent_len;
				end else begin
					free_sum_q <= free_sum_q - len_q[LW-1:0];
					used_sum_q <= used_sum_q + len_q[LW-1:0];
				end
			end

			if (ins_done) begin
				if (tbl_used) begin
					used_cnt_q <= used_cnt_q + CW'(1);
				end else begin
					free_cnt_q <= free_cnt_q + CW'(1);
				end
			end else if (rem_done) begin
				if (tbl_used) begin
					used_cnt_q <= used_cnt_q - CW'(1);
				end else begin
					free_cnt_q <= free_cnt_q - CW'(1);
				end
			end

			if (f_we && (wr_idx == '0)) begin
				boot_q <= 1'b0;
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign s_ext    = DW'(s_q);
	assign free_ext = DW'(free_sum_q);
	assign used_ext = DW'(used_sum_q);

	always_ff @(posedge clk) begin
		ovr_s1 <= boot_q && (rd_idx == '0);

		if (in_acc) begin
			mode_q   <= mode;
			addr_q   <= region_address;
			reqb_q   <= request_bytes;
			ptr_q    <= '0;
			status_q <= ((mode == MODE_ALLOC) && (request_bytes == '0)) ? ST_NOFIT : ST_OK;
		end

		case (state_q)
			S_ROUND: prod_q <= prod_d;
			S_SIZE:  len_q  <= DW'(size_full[SIZE_W-1:0]);
			S_SCAN: begin
				if (scan_issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (scan_hit) begin
					idx_q <= ptr_m1[AW-1:0];
					s_q   <= ent_start;
					rem_q <= alu_diff[LW-1:0];
					if (mode_q == MODE_FREE) begin
						len_q <= DW'(ent_len);
					end
					if (tbl_full) begin
						status_q <= ST_FULL;
					end
				end else if (scan_miss) begin
					status_q <= (mode_q == MODE_FREE) ? ST_NOADDR : ST_NOFIT;
				end
			end
			S_INS0: ptr_q <= tbl_cnt;
			S_INS: begin
				if (ins_shift) begin
					ptr_q <= ptr_m1;
				end
			end
			S_REM0: ptr_q <= CW'(idx_q);
			S_REM: begin
				if (rd_vld_s1) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					rsp_granted_q <= ((status_q == ST_OK) && (mode_q == MODE_ALLOC)) ?
						s_ext[ADDR_W-1:0] : '0;
					rsp_status_q  <= status_q;
					rsp_free_q    <= free_ext[SUM_W-1:0];
					rsp_alloc_q   <= used_ext[SUM_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid       = rsp_valid_q;
	assign granted_address = rsp_granted_q;
	assign status          = rsp_status_q;
	assign free_bytes      = rsp_free_q;
	assign allocated_bytes = rsp_alloc_q;

	// Splitting and moving regions never creates or loses bytes.
	ap_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, free_sum_q} + {1'b0, used_sum_q}) == {1'b0, HEAP_LEN})
		else $error("free and allocated byte totals do not add up to the heap");

	ap_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && (free_cnt_q == '0)) |-> (free_sum_q == '0))
		else $error("empty free table with nonzero free bytes");

	ap_used_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && (used_cnt_q == '0)) |-> (used_sum_q == '0))
		else $error("empty allocated table with nonzero allocated bytes");

	ap_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the done state");

	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after taking a request beat");

endmodule

// ----- hw/rtl/ffha_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the free and allocated region tables.
module ffha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/ffha_alu.sv -----
// Shared subtract/compare unit of the allocator sequencer.
// Depends on ffha_pkg for the flag struct.
module ffha_alu import ffha_pkg::*; #(
	parameter int unsigned W = 17
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output ffha_flags_t  flags
);

	logic [W:0] full;

	assign full         = {1'b0, a} - {1'b0, b};
	assign diff         = full[W-1:0];
	assign flags.borrow = full[W];
	assign flags.zero   = (full == '0);

endmodule
